// ===== rtl/msp_pkg.sv =====
// Shared types and constants for the multi-stack shared-pool block.
package msp_pkg;

	localparam int STACKS_DEF = 8;
	localparam int SLOTS_DEF  = 256;
	localparam int SID_W      = 3;
	localparam int DATA_W     = 32;
	localparam int STATUS_W   = 2;

	// Operation codes
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	// Response status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic                     kind;
		logic [SID_W-1:0]         stack_id;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] popped_value;
	} rsp_t;

endpackage

// ===== rtl/msp_slot_mem.sv =====
// Slot pool storage: one data memory and one link memory, with registered read outputs.
module msp_slot_mem #(
	parameter int SLOTS  = msp_pkg::SLOTS_DEF,
	parameter int ADDR_W = $clog2(SLOTS),
	parameter int PTR_W  = $clog2(SLOTS + 1)
) (
	input  logic                             clk,
	input  logic                             rd_en,
	input  logic [ADDR_W-1:0]                rd_addr,
	output logic [PTR_W-1:0]                 rd_link,
	output logic signed [msp_pkg::DATA_W-1:0] rd_data,
	input  logic                             wr_en,
	input  logic                             wr_data_en,
	input  logic [ADDR_W-1:0]                wr_addr,
	input  logic [PTR_W-1:0]                 wr_link,
	input  logic signed [msp_pkg::DATA_W-1:0] wr_data
);

	logic [PTR_W-1:0]                 link_mem [SLOTS];
	logic signed [msp_pkg::DATA_W-1:0] data_mem [SLOTS];

	// Link memory: written on every successful push or pop
	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[wr_addr] <= wr_link;
		end
		if (rd_en) begin
			rd_link <= link_mem[rd_addr];
		end
	end

	// Data memory: written by pushes only
	always_ff @(posedge clk) begin
		if (wr_en && wr_data_en) begin
			data_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= data_mem[rd_addr];
		end
	end

endmodule

// ===== rtl/multi_stack_shared_pool.sv =====
// Each request reads slot memory, then runs its link/data writeback; the response register
// is loaded at writeback, which waits while an earlier response is stalled on rsp.
// A new request is taken only once the block is back in idle after that writeback.
// Reset clears all stack heads to null, sets the free-list head to slot 0 and the
// fill mark to 0; slots at or above the fill mark read as the initial chain, so
// no clearing pass is run and requests are taken right after reset.
module multi_stack_shared_pool #(
	parameter int STACKS = msp_pkg::STACKS_DEF,
	parameter int SLOTS  = msp_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  msp_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output msp_pkg::rsp_t rsp
);

	localparam int ADDR_W = $clog2(SLOTS);
	localparam int PTR_W  = $clog2(SLOTS + 1);
	localparam int IDX_W  = (STACKS > 1) ? $clog2(STACKS) : 1;
	localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_BUSY = 1'b1;

	logic             state_q;
	logic [PTR_W-1:0] head_q [STACKS];
	logic [PTR_W-1:0] free_head_q;
	logic [PTR_W-1:0] hwm_q;
	logic             rsp_valid_q;
	msp_pkg::rsp_t    rsp_q;

	// Stage-1 request context
	logic                              kind_s1;
	logic                              ok_s1;
	logic                              fresh_s1;
	logic [IDX_W-1:0]                  idx_s1;
	logic [PTR_W-1:0]                  slot_s1;
	logic [PTR_W-1:0]                  old_head_s1;
	logic signed [msp_pkg::DATA_W-1:0] value_s1;

	logic                              accept;
	logic                              done;
	logic                              sid_ok;
	logic [IDX_W-1:0]                  idx;
	logic [PTR_W-1:0]                  sel_head;
	logic                              push_ok;
	logic                              pop_ok;
	logic [PTR_W-1:0]                  rd_ptr;
	logic [PTR_W-1:0]                  rd_link;
	logic signed [msp_pkg::DATA_W-1:0] rd_data;
	logic                              wr_en;
	logic                              wr_data_en;
	logic [PTR_W-1:0]                  wr_link;
	logic [PTR_W-1:0]                  next_free;
	logic [PTR_W-1:0]                  next_head;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign done      = (state_q == S_BUSY) && (!rsp_valid_q || rsp_ready);

	// Request decode against current heads
	assign sid_ok   = int'(req.stack_id) < STACKS;
	assign idx      = IDX_W'(req.stack_id);
	assign sel_head = head_q[idx];
	assign push_ok  = sid_ok && (free_head_q < NIL);
	assign pop_ok   = sid_ok && (sel_head < NIL);
	assign rd_ptr   = (req.kind == msp_pkg::KIND_PUSH) ? free_head_q : sel_head;

	// Writeback: push links the slot on its stack, pop returns it to the free list
	assign wr_en      = done && ok_s1;
	assign wr_data_en = (kind_s1 == msp_pkg::KIND_PUSH);
	assign wr_link    = (kind_s1 == msp_pkg::KIND_PUSH) ? old_head_s1 : free_head_q;
	assign next_free  = (kind_s1 == msp_pkg::KIND_POP) ? slot_s1 :
		(fresh_s1 ? PTR_W'(slot_s1 + 1'b1) : rd_link);
	assign next_head  = (kind_s1 == msp_pkg::KIND_PUSH) ? slot_s1 : rd_link;

	msp_slot_mem #(
		.SLOTS (SLOTS),
		.ADDR_W(ADDR_W),
		.PTR_W (PTR_W)
	) u_mem (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr   (rd_ptr[ADDR_W-1:0]),
		.rd_link   (rd_link),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_data_en(wr_data_en),
		.wr_addr   (slot_s1[ADDR_W-1:0]),
		.wr_link   (wr_link),
		.wr_data   (value_s1)
	);

	// Sequencer and pool pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_head_q <= '0;
			hwm_q       <= '0;
			for (int i = 0; i < STACKS; i++) begin
				head_q[i] <= NIL;
			end
		end else begin
			if (accept) begin
				state_q <= S_BUSY;
			end else if (done) begin
				state_q <= S_IDLE;
			end
			if (wr_en) begin
				head_q[idx_s1] <= next_head;
				free_head_q    <= next_free;
				if (kind_s1 == msp_pkg::KIND_PUSH && fresh_s1) begin
					hwm_q <= PTR_W'(hwm_q + 1'b1);
				end
			end
		end
	end

	// Request context capture
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= req.kind;
			ok_s1       <= (req.kind == msp_pkg::KIND_PUSH) ? push_ok : pop_ok;
			fresh_s1    <= (free_head_q == hwm_q);
			idx_s1      <= idx;
			slot_s1     <= rd_ptr;
			old_head_s1 <= sel_head;
			value_s1    <= req.value;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			if (ok_s1) begin
				rsp_q.status <= msp_pkg::STAT_OK;
			end else if (kind_s1 == msp_pkg::KIND_PUSH) begin
				rsp_q.status <= msp_pkg::STAT_OVERFLOW;
			end else begin
				rsp_q.status <= msp_pkg::STAT_UNDERFLOW;
			end
			rsp_q.popped_value <= (ok_s1 && kind_s1 == msp_pkg::KIND_POP) ? rd_data : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/msp_checker.sv =====
// Port-level checks for the multi-stack shared-pool block, bound to the top level.
module msp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input msp_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input msp_pkg::rsp_t rsp
);

	// A held response stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// One request in flight: no back-to-back acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// Only defined status codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == msp_pkg::STAT_OK ||
			rsp.status == msp_pkg::STAT_OVERFLOW ||
			rsp.status == msp_pkg::STAT_UNDERFLOW))
		else $error("undefined status code");

	// Failed requests carry a zero value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != msp_pkg::STAT_OK |-> rsp.popped_value == '0)
		else $error("failed request returned nonzero value");

endmodule

bind multi_stack_shared_pool msp_checker u_msp_checker (.*);
